/* rtl/shkf_pkg.sv */
// ----------------------------------------------------------------------------
// shkf_pkg
// Shared types and operation codes of the scalar adaptive Kalman filter.
// ----------------------------------------------------------------------------
package shkf_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned RegIdxW    = 3;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegInitEst  = 3'd0;
  localparam logic [RegIdxW-1:0] RegInitCov  = 3'd1;
  localparam logic [RegIdxW-1:0] RegInitQ    = 3'd2;
  localparam logic [RegIdxW-1:0] RegInitR    = 3'd3;
  localparam logic [RegIdxW-1:0] RegForgetQ  = 3'd4;
  localparam logic [RegIdxW-1:0] RegForgetR  = 3'd5;
  localparam logic [RegIdxW-1:0] RegTransF   = 3'd6;
  localparam logic [RegIdxW-1:0] RegObsH     = 3'd7;

  typedef struct packed {
    logic [31:0] measurement;
    logic        restart;
  } shkf_in_t;

  typedef struct packed {
    logic [31:0] estimate;
    logic [31:0] gain;
    logic [31:0] process_noise_est;
    logic [31:0] measurement_noise_est;
    logic        degenerate;
    logic        saturated;
  } shkf_out_t;

  // datapath operations
  typedef enum logic [2:0] {
    OpMul    = 3'd0,  // a*b >> FRAC_BITS
    OpMulF   = 3'd1,  // a*b >> FORGET_BITS
    OpAdd    = 3'd2,
    OpSub    = 3'd3,
    OpDiv    = 3'd4,
    OpMov    = 3'd5
  } shkf_op_e;

  // operand / destination register-file slots
  typedef enum logic [4:0] {
    SlF, SlH, SlZ, SlX, SlP, SlQ, SlR, SlXp, SlPp, SlEps, SlDen, SlK, SlNu,
    SlT0, SlT1, SlT2, SlT3, SlOne, SlWq, SlOwq, SlWr, SlOwr, SlZero, SlNum
  } shkf_slot_e;

  typedef struct packed {
    logic       start;     // launch one operation
    shkf_op_e   op;
    shkf_slot_e src_a;
    shkf_slot_e src_b;
    shkf_slot_e dst;
    logic       load;      // fill work slots from registers and input
    logic       restart;   // reload state from initial registers
    logic       gain_zero; // force gain to zero, set degenerate
    logic       clear;     // clear item flags
  } shkf_cmd_t;

  typedef struct packed {
    logic busy;       // an operation is in progress
    logic den_pos;    // denominator slot is positive
  } shkf_sts_t;

endpackage

/* rtl/shkf_datapath.sv */
// ----------------------------------------------------------------------------
// shkf_datapath
// Register file, shared fixed-point multiplier, adder and radix-2 divider.
// ----------------------------------------------------------------------------
module shkf_datapath import shkf_pkg::*; #(
  parameter int unsigned DATA_WIDTH  = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned FORGET_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shkf_cmd_t       cmd_i,
  output shkf_sts_t       sts_o,
  input  logic [31:0]     reg_est_i,
  input  logic [30:0]     reg_cov_i,
  input  logic [30:0]     reg_q_i,
  input  logic [30:0]     reg_r_i,
  input  logic [15:0]     reg_fq_i,
  input  logic [15:0]     reg_fr_i,
  input  logic [31:0]     reg_f_i,
  input  logic [31:0]     reg_h_i,
  input  logic [31:0]     meas_i,
  output shkf_out_t       res_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned DW  = W + FRAC_BITS;
  localparam int unsigned CW  = $clog2(DW + 1);
  localparam int unsigned NS  = SlNum;

  typedef logic signed [W-1:0] word_t;

  localparam word_t VMax = word_t'({1'b0, {(W-1){1'b1}}});
  localparam word_t VMin = word_t'({1'b1, {(W-1){1'b0}}});

  word_t rf_q [NS];
  logic  clip_q, degen_q;

  // saturate a 32-bit field to the data width
  function automatic word_t sat_field(input logic signed [47:0] v, output logic c);
    logic signed [48:0] e;
    e = 49'(v);
    c = 1'b0;
    if (e > 49'(VMax)) begin
      c = 1'b1;
      return VMax;
    end else if (e < 49'(VMin)) begin
      c = 1'b1;
      return VMin;
    end
    return word_t'(e);
  endfunction

  // magnitude to saturated signed word
  function automatic word_t from_mag(input logic neg, input logic [PW-1:0] mag,
                                     output logic c);
    logic [PW-1:0] lim;
    logic [PW-1:0] m;
    lim = neg ? PW'({1'b1, {(W-1){1'b0}}}) : PW'({1'b0, {(W-1){1'b1}}});
    m = mag;
    c = 1'b0;
    if (m > lim) begin
      c = 1'b1;
      m = lim;
    end
    return neg ? word_t'(-m) : word_t'(m);
  endfunction

  word_t a_w, b_w;
  assign a_w = rf_q[cmd_i.src_a];
  assign b_w = rf_q[cmd_i.src_b];

  // operation registers
  shkf_op_e       op_q;
  shkf_slot_e     dst_q;
  logic [1:0]     ph_q;      // multiply phases
  logic           busy_q;
  logic [W-1:0]   ua_q, ub_q;
  logic           neg_q;
  logic [PW-1:0]  prod_q;
  word_t          sa_q, sb_q;
  // divider
  logic [DW-1:0]  dnum_q;
  logic [W:0]     rem_q;
  logic [W:0]     quo_q;
  logic           dov_q;
  logic [W-1:0]   dden_q;
  logic [CW-1:0]  dcnt_q;

  assign sts_o.busy    = busy_q;
  assign sts_o.den_pos = (rf_q[SlDen] > 0);

  // add / sub result
  logic signed [W:0] sum_w;
  assign sum_w = (op_q == OpSub) ? (W+1)'(sa_q) - (W+1)'(sb_q)
                                 : (W+1)'(sa_q) + (W+1)'(sb_q);

  // divider step
  logic [W:0]  rs_w;
  logic        rge_w;
  logic [W:0]  qn_w;
  always_comb begin
    rs_w  = {rem_q[W-1:0], dnum_q[DW-1]};
    rge_w = rs_w >= (W+1)'(dden_q);
    qn_w  = {quo_q[W-1:0], rge_w};
  end

  logic [PW-1:0] shifted_w;
  logic          over_w;
  always_comb begin
    if (op_q == OpMulF) begin
      shifted_w = prod_q >> FORGET_BITS;
    end else begin
      shifted_w = prod_q >> FRAC_BITS;
    end
    over_w = 1'b0;
  end

  // register file, operation sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic c;
    word_t r;
    logic signed [W:0] tmp;
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      clip_q  <= 1'b0;
      degen_q <= 1'b0;
      ph_q    <= '0;
      // state slots take the initial register defaults
      for (int i = 0; i < NS; i++) begin
        if (i == int'(SlP)) rf_q[i] <= word_t'(6553600);
        else if (i == int'(SlQ)) rf_q[i] <= word_t'(9830);
        else if (i == int'(SlR)) rf_q[i] <= word_t'(5898240);
        else rf_q[i] <= '0;
      end
    end else begin
      c = 1'b0;
      r = '0;
      if (cmd_i.clear) begin
        clip_q  <= 1'b0;
        degen_q <= 1'b0;
        rf_q[SlK] <= '0;
      end
      if (cmd_i.load) begin
        rf_q[SlF] <= sat_field(48'(signed'(reg_f_i)), c);
        rf_q[SlH] <= sat_field(48'(signed'(reg_h_i)), c);
        rf_q[SlZ] <= sat_field(48'(signed'(meas_i)), c);
        rf_q[SlOne] <= word_t'(1 << FRAC_BITS);
        rf_q[SlZero] <= '0;
        rf_q[SlWq]  <= word_t'(reg_fq_i);
        rf_q[SlOwq] <= word_t'((1 << FORGET_BITS) - int'(reg_fq_i));
        rf_q[SlWr]  <= word_t'(reg_fr_i);
        rf_q[SlOwr] <= word_t'((1 << FORGET_BITS) - int'(reg_fr_i));
        if (c) clip_q <= 1'b1;
      end
      if (cmd_i.restart) begin
        logic c0, c1, c2, c3;
        rf_q[SlX] <= sat_field(48'(signed'(reg_est_i)), c0);
        rf_q[SlP] <= sat_field(48'({1'b0, reg_cov_i}), c1);
        rf_q[SlQ] <= sat_field(48'({1'b0, reg_q_i}), c2);
        rf_q[SlR] <= sat_field(48'({1'b0, reg_r_i}), c3);
        rf_q[SlK] <= '0;
        clip_q  <= c0 | c1 | c2 | c3;
        degen_q <= 1'b0;
      end
      if (cmd_i.gain_zero) begin
        rf_q[SlK] <= '0;
        degen_q   <= 1'b1;
      end
      if (cmd_i.start) begin
        op_q   <= cmd_i.op;
        dst_q  <= cmd_i.dst;
        busy_q <= 1'b1;
        ph_q   <= '0;
        sa_q   <= a_w;
        sb_q   <= b_w;
        neg_q  <= (a_w < 0) != (b_w < 0);
        ua_q   <= (a_w < 0) ? W'(-a_w) : W'(a_w);
        ub_q   <= (b_w < 0) ? W'(-b_w) : W'(b_w);
        // divider setup: numerator a, denominator b (positive)
        dnum_q <= {((a_w < 0) ? W'(-a_w) : W'(a_w)), {FRAC_BITS{1'b0}}};
        dden_q <= W'(b_w);
        rem_q  <= '0;
        quo_q  <= '0;
        dov_q  <= 1'b0;
        dcnt_q <= CW'(DW);
      end else if (busy_q) begin
        case (op_q)
          OpMul, OpMulF: begin
            if (ph_q == 2'd0) begin
              prod_q <= PW'(ua_q) * PW'(ub_q);
              ph_q   <= 2'd1;
            end else begin
              rf_q[dst_q] <= from_mag(neg_q, shifted_w, c);
              if (c) clip_q <= 1'b1;
              busy_q <= 1'b0;
            end
          end
          OpAdd, OpSub: begin
            tmp = sum_w;
            if (tmp > (W+1)'(VMax)) begin
              r = VMax;
              clip_q <= 1'b1;
            end else if (tmp < (W+1)'(VMin)) begin
              r = VMin;
              clip_q <= 1'b1;
            end else begin
              r = word_t'(tmp);
            end
            rf_q[dst_q] <= r;
            busy_q <= 1'b0;
          end
          OpDiv: begin
            if (dcnt_q != '0) begin
              dnum_q <= {dnum_q[DW-2:0], 1'b0};
              rem_q  <= rge_w ? rs_w - (W+1)'(dden_q) : rs_w;
              if (qn_w > (W+1)'({1'b1, {(W-1){1'b0}}})) begin
                quo_q <= (W+1)'({1'b1, {(W-1){1'b0}}});
                dov_q <= 1'b1;
              end else begin
                quo_q <= qn_w;
              end
              dcnt_q <= dcnt_q - 1'b1;
            end else begin
              rf_q[dst_q] <= from_mag(sa_q < 0, PW'(quo_q), c);
              if (c || dov_q) clip_q <= 1'b1;
              busy_q <= 1'b0;
            end
          end
          default: begin
            rf_q[dst_q] <= sa_q;
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign res_o.estimate              = 32'(rf_q[SlX]);
  assign res_o.gain                  = 32'(rf_q[SlK]);
  assign res_o.process_noise_est     = 32'(rf_q[SlQ]);
  assign res_o.measurement_noise_est = 32'(rf_q[SlR]);
  assign res_o.degenerate            = degen_q;
  assign res_o.saturated             = clip_q | over_w;

endmodule

/* rtl/shkf_ctrl.sv */
// ----------------------------------------------------------------------------
// shkf_ctrl
// Sequencer: steps through the filter's operation list, one op at a time.
// ----------------------------------------------------------------------------
module shkf_ctrl import shkf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      restart_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      cap_o,
  output shkf_cmd_t cmd_o,
  input  shkf_sts_t sts_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StIssue = 5'b00010,
    StWait = 5'b00100,
    StDone = 5'b01000,
    StOut = 5'b10000
  } state_e;

  typedef struct packed {
    shkf_op_e   op;
    shkf_slot_e a;
    shkf_slot_e b;
    shkf_slot_e d;
  } step_t;

  function automatic step_t prog(input logic [5:0] i);
    case (i)
      6'd0:  return '{OpMul, SlF, SlX, SlXp};
      6'd1:  return '{OpMul, SlF, SlP, SlT0};
      6'd2:  return '{OpMul, SlT0, SlF, SlT0};     // F*P*F (old P)
      6'd3:  return '{OpAdd, SlT0, SlQ, SlPp};
      6'd4:  return '{OpMul, SlH, SlXp, SlT1};
      6'd5:  return '{OpSub, SlZ, SlT1, SlEps};
      6'd6:  return '{OpMul, SlH, SlPp, SlT1};
      6'd7:  return '{OpMul, SlT1, SlH, SlT3};     // H*Pp*H
      6'd8:  return '{OpAdd, SlT3, SlR, SlDen};
      6'd9:  return '{OpMul, SlPp, SlH, SlT1};     // gain numerator
      6'd10: return '{OpDiv, SlT1, SlDen, SlK};    // skipped when degenerate
      6'd11: return '{OpMul, SlK, SlEps, SlT1};
      6'd12: return '{OpAdd, SlXp, SlT1, SlX};
      6'd13: return '{OpMul, SlK, SlH, SlT1};
      6'd14: return '{OpSub, SlOne, SlT1, SlT1};
      6'd15: return '{OpMul, SlT1, SlPp, SlP};
      6'd16: return '{OpMul, SlH, SlX, SlT1};
      6'd17: return '{OpSub, SlZ, SlT1, SlNu};
      6'd18: return '{OpMul, SlK, SlNu, SlT1};
      6'd19: return '{OpMul, SlT1, SlNu, SlT1};
      6'd20: return '{OpMul, SlT1, SlK, SlT1};
      6'd21: return '{OpAdd, SlT1, SlPp, SlT1};
      6'd22: return '{OpMul, SlF, SlP, SlT2};
      6'd23: return '{OpMul, SlT2, SlF, SlT2};
      6'd24: return '{OpSub, SlT1, SlT2, SlT1};    // dq
      6'd25: return '{OpMul, SlNu, SlNu, SlT2};
      6'd26: return '{OpSub, SlT2, SlT3, SlT2};    // dr
      6'd27: return '{OpMulF, SlWq, SlQ, SlT0};
      6'd28: return '{OpMulF, SlOwq, SlT1, SlT1};
      6'd29: return '{OpAdd, SlT0, SlT1, SlQ};
      6'd30: return '{OpMulF, SlWr, SlR, SlT0};
      6'd31: return '{OpMulF, SlOwr, SlT2, SlT2};
      6'd32: return '{OpAdd, SlT0, SlT2, SlR};
      default: return '{OpMov, SlZero, SlZero, SlT0};
    endcase
  endfunction

  state_e     state_q, state_d;
  logic [5:0] pc_q, pc_d;
  step_t      st_w;

  assign st_w = prog(pc_q);

  // next state and commands
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cmd_o   = '0;
    cmd_o.op    = st_w.op;
    cmd_o.src_a = st_w.a;
    cmd_o.src_b = st_w.b;
    cmd_o.dst   = st_w.d;
    cap_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          pc_d = '0;
          if (restart_i) begin
            cmd_o.restart = 1'b1;
            state_d = StDone;
          end else begin
            cmd_o.clear = 1'b1;
            state_d = StIssue;
          end
        end
      end
      StIssue: begin
        if (pc_q == 6'd10 && !sts_i.den_pos) begin
          cmd_o.gain_zero = 1'b1;
          pc_d = pc_q + 6'd1;
        end else begin
          cmd_o.start = 1'b1;
          state_d = StWait;
        end
      end
      StWait: begin
        if (!sts_i.busy) begin
          if (pc_q == 6'd32) begin
            state_d = StDone;
          end else begin
            pc_d = pc_q + 6'd1;
            state_d = StIssue;
          end
        end
      end
      StDone: begin
        cap_o = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

/* rtl/sage_husa_kalman_filter.sv */
// ----------------------------------------------------------------------------
// sage_husa_kalman_filter
// Scalar adaptive Kalman filter, Q16.16, sequencer plus shared datapath.
// ----------------------------------------------------------------------------
// channel   signals                     direction
// in        in_valid_i/in_stall_o/in_i  item: measurement, restart
// out       out_valid_o/out_stall_i     result: estimate, gain, Q, R, flags
// cfg       cfg_we_i/cfg_idx_i/cfg_data_i  register writes
//
// A filter item runs 33 dependent ops issued one at a time (multiplies, adds
// and subtracts, and the 48-step radix-2 divide), plus accept, capture, output.
// A non-positive denominator skips the divide. A restart item skips the ops.
// Reset loads the initial register defaults.
// One item at a time; the result is held in an output register under stall.
// ----------------------------------------------------------------------------
module sage_husa_kalman_filter import shkf_pkg::*; #(
  parameter int unsigned DATA_WIDTH  = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned FORGET_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  shkf_in_t           in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output shkf_out_t          out_o,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0] est_q, f_q, h_q;
  logic [30:0] cov_q, iq_q, ir_q;
  logic [15:0] fq_q, fr_q;
  logic [31:0] meas_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= 31'd6553600;
      iq_q  <= 31'd9830;
      ir_q  <= 31'd5898240;
      fq_q  <= 16'd64880;
      fr_q  <= 16'd64880;
      f_q   <= 32'd65536;
      h_q   <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInitEst: est_q <= cfg_data_i;
        RegInitCov: cov_q <= cfg_data_i[30:0];
        RegInitQ:   iq_q  <= cfg_data_i[30:0];
        RegInitR:   ir_q  <= cfg_data_i[30:0];
        RegForgetQ: fq_q  <= cfg_data_i[15:0];
        RegForgetR: fr_q  <= cfg_data_i[15:0];
        RegTransF:  f_q   <= cfg_data_i;
        RegObsH:    h_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  shkf_cmd_t cmd;
  shkf_sts_t sts;
  shkf_out_t res;
  logic      cap;

  assign meas_q = in_i.measurement;

  shkf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .restart_i(in_i.restart),
    .out_valid_o, .out_stall_i, .cap_o(cap), .cmd_o(cmd), .sts_i(sts)
  );

  shkf_datapath #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .FORGET_BITS(FORGET_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .reg_est_i(est_q), .reg_cov_i(cov_q), .reg_q_i(iq_q), .reg_r_i(ir_q),
    .reg_fq_i(fq_q), .reg_fr_i(fr_q), .reg_f_i(f_q), .reg_h_i(h_q),
    .meas_i(meas_q), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (cap) out_o <= res;
  end

`ifndef SYNTHESIS
  // no new transaction while a result waits
  a_no_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept during result");
  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result dropped");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scalar adaptive Kalman filter. A queue-fed
// driver offers measurement and restart transactions with random gaps. A
// clocked monitor with random and long stalls compares every result field
// against a fixed-point predictor. The run covers several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import shkf_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam longint VMax = 64'sd2147483647;
  localparam longint VMin = -64'sd2147483648;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  shkf_in_t           in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  shkf_out_t          out_o;
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [31:0]        cfg_data_i;

  sage_husa_kalman_filter DUT (.*);

  // clock
  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // register shadow and filter state of the predictor
  logic [31:0] shadow_reg [NumRegs];
  longint      est_x, cov_p, noise_q, noise_r;
  bit          clip_seen;

  shkf_in_t    pending_items[$];
  shkf_out_t   expected_results[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned results_seen;

  function automatic longint sat_word(longint v);
    if (v > VMax) begin clip_seen = 1'b1; return VMax; end
    if (v < VMin) begin clip_seen = 1'b1; return VMin; end
    return v;
  endfunction

  function automatic longint from_magnitude(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin clip_seen = 1'b1; mag = lim; end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic logic [63:0] magnitude(longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // truncating fixed-point product, saturated
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic [127:0] prod;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    return from_magnitude((a < 0) != (b < 0), prod >> sh);
  endfunction

  function automatic longint fm(longint a, longint b);
    return fx_mul(a, b, 16);
  endfunction

  function automatic longint fadd(longint a, longint b);
    return sat_word(a + b);
  endfunction

  function automatic longint fsub(longint a, longint b);
    return sat_word(a - b);
  endfunction

  // den is positive here
  function automatic longint fx_div(longint num, longint den);
    logic [127:0] quot;
    quot = ({64'd0, magnitude(num)} << 16) / {64'd0, 64'(den)};
    return from_magnitude(num < 0, quot);
  endfunction

  function automatic longint noise_blend(longint old_v, longint fresh, logic [15:0] w);
    return fadd(fx_mul(longint'(w), old_v, 16),
                fx_mul(65536 - longint'(w), fresh, 16));
  endfunction

  function automatic void load_initial();
    est_x   = longint'($signed(shadow_reg[RegInitEst]));
    cov_p   = longint'(shadow_reg[RegInitCov]);
    noise_q = longint'(shadow_reg[RegInitQ]);
    noise_r = longint'(shadow_reg[RegInitR]);
  endfunction

  // one filter step on the predictor state
  function automatic shkf_out_t filter_step(shkf_in_t item);
    shkf_out_t res;
    longint f, h, z, xp, pp, eps, den, nu, dq, dr, k;
    bit degen;
    k = 0;
    degen = 1'b0;
    clip_seen = 1'b0;
    if (item.restart) begin
      load_initial();
    end else begin
      f   = longint'($signed(shadow_reg[RegTransF]));
      h   = longint'($signed(shadow_reg[RegObsH]));
      z   = longint'($signed(item.measurement));
      xp  = fm(f, est_x);
      pp  = fadd(fm(fm(f, cov_p), f), noise_q);
      eps = fsub(z, fm(h, xp));
      den = fadd(fm(fm(h, pp), h), noise_r);
      if (den <= 0) degen = 1'b1;
      else k = fx_div(fm(pp, h), den);
      est_x = fadd(xp, fm(k, eps));
      cov_p = fm(fsub(65536, fm(k, h)), pp);
      nu = fsub(z, fm(h, est_x));
      dq = fsub(fadd(fm(fm(fm(k, nu), nu), k), pp), fm(fm(f, cov_p), f));
      dr = fsub(fm(nu, nu), fm(fm(h, pp), h));
      noise_q = noise_blend(noise_q, dq, shadow_reg[RegForgetQ][15:0]);
      noise_r = noise_blend(noise_r, dr, shadow_reg[RegForgetR][15:0]);
    end
    res.estimate              = est_x[31:0];
    res.gain                  = k[31:0];
    res.process_noise_est     = noise_q[31:0];
    res.measurement_noise_est = noise_r[31:0];
    res.degenerate            = degen;
    res.saturated             = clip_seen;
    return res;
  endfunction

  // driver: offers pending transactions with random gaps
  int unsigned send_gap;
  bit          send_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    logic     nv;
    shkf_in_t np;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
      send_gap    = 0;
      send_burst  = 1'b0;
    end else begin
      nv = in_valid_i;
      np = in_i;
      if (nv && !in_stall_o) begin
        expected_results.push_back(filter_step(in_i));
        nv = 1'b0;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 18);
      end
      if (!nv) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          np = pending_items.pop_front();
          nv = 1'b1;
        end
      end
      in_valid_i <= nv;
      in_i       <= np;
    end
  end

  // monitor: random stalls, one long hold-off, field checks
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  bit          recv_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    shkf_out_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      recv_burst   = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_o);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_o !== exp_res) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p actual %p", exp_res, out_o);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 18);
        if (results_seen == 120 && !hold_done) begin
          hold_left = 800;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else if (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] data);
    logic [31:0] mask;
    case (idx)
      RegInitCov, RegInitQ, RegInitR: mask = 32'h7FFF_FFFF;
      RegForgetQ, RegForgetR:         mask = 32'h0000_FFFF;
      default:                        mask = 32'hFFFF_FFFF;
    endcase
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    shadow_reg[idx] = data & mask;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0);
  endtask

  function automatic void push_item(logic [31:0] z, logic rs);
    shkf_in_t it;
    it.measurement = z;
    it.restart     = rs;
    pending_items.push_back(it);
  endfunction

  // random tracking run: mostly plausible measurements, some noise and restarts
  function automatic void push_random(int unsigned n);
    logic [31:0] z;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       z = $urandom;
        1:       z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        2, 3, 4: z = 32'(est_x) + 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF);
        default: z = $signed($urandom_range(0, 32'hF_FFFF)) - 32'h7_FFFF;
      endcase
      push_item(z, $urandom_range(0, 24) == 0);
    end
  endfunction

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegInitEst;
    cfg_data_i = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    results_seen   = 0;
    shadow_reg[RegInitEst] = 32'd0;
    shadow_reg[RegInitCov] = 32'd6553600;
    shadow_reg[RegInitQ]   = 32'd9830;
    shadow_reg[RegInitR]   = 32'd5898240;
    shadow_reg[RegForgetQ] = 32'd64880;
    shadow_reg[RegForgetR] = 32'd64880;
    shadow_reg[RegTransF]  = 32'd65536;
    shadow_reg[RegObsH]    = 32'd65536;
    load_initial();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset defaults, field extremes and restarts
    push_item(32'd0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'd1, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0001_0000, 1'b0);
    push_item(32'hFFFF_0000, 1'b1);
    push_item(32'h0005_0000, 1'b0);
    push_item(32'h0005_8000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b1);
    push_random(110);
    wait_idle();

    // random register values on every index
    for (int i = 0; i < NumRegs; i++) write_reg(i[RegIdxW-1:0], $urandom);
    write_reg(RegTransF, $signed($urandom_range(0, 32'h2_0000)) - 32'h1_0000);
    write_reg(RegObsH, $signed($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
    write_reg(RegInitCov, $urandom_range(0, 32'h0100_0000));
    end_writes();
    push_item($urandom, 1'b1);
    push_random(100);
    wait_idle();

    // extremes: largest values, forgetting factors 0 and full
    write_reg(RegInitEst, 32'h7FFF_FFFF);
    write_reg(RegInitCov, 32'hFFFF_FFFF);
    write_reg(RegInitQ, 32'h7FFF_FFFF);
    write_reg(RegInitR, 32'h7FFF_FFFF);
    write_reg(RegForgetQ, 32'd0);
    write_reg(RegForgetR, 32'h0000_FFFF);
    write_reg(RegTransF, 32'h7FFF_FFFF);
    write_reg(RegObsH, 32'h8000_0000);
    end_writes();
    push_item(32'd0, 1'b1);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_random(90);
    wait_idle();

    // degenerate denominator: no observation, no noise
    write_reg(RegInitEst, 32'h8000_0000);
    write_reg(RegInitCov, 32'd0);
    write_reg(RegInitQ, 32'd0);
    write_reg(RegInitR, 32'd0);
    write_reg(RegForgetQ, 32'h0000_FFFF);
    write_reg(RegForgetR, 32'd0);
    write_reg(RegTransF, 32'd0);
    write_reg(RegObsH, 32'd0);
    end_writes();
    push_item(32'h1234_5678, 1'b1);
    push_item(32'h0001_0000, 1'b0);
    push_random(60);
    wait_idle();

    // moderate tracking settings, one negative transition
    write_reg(RegInitEst, $urandom_range(0, 32'hF_FFFF));
    write_reg(RegInitCov, 32'h000A_0000);
    write_reg(RegInitQ, 32'h0000_1000);
    write_reg(RegInitR, 32'h0002_0000);
    write_reg(RegForgetQ, $urandom_range(60000, 65535));
    write_reg(RegForgetR, $urandom_range(60000, 65535));
    write_reg(RegTransF, 32'hFFFF_0000);
    write_reg(RegObsH, 32'h0000_8000);
    end_writes();
    push_item(32'd0, 1'b1);
    push_random(120);
    wait_idle();

    // back to defaults for a final stretch
    write_reg(RegInitEst, 32'd0);
    write_reg(RegInitCov, 32'd6553600);
    write_reg(RegInitQ, 32'd9830);
    write_reg(RegInitR, 32'd5898240);
    write_reg(RegForgetQ, 32'd64880);
    write_reg(RegForgetR, 32'd64880);
    write_reg(RegTransF, 32'd65536);
    write_reg(RegObsH, 32'd65536);
    end_writes();
    push_item(32'd0, 1'b1);
    push_random(150);
    wait_idle();

    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/shkf_pkg.sv
rtl/shkf_datapath.sv
rtl/shkf_ctrl.sv
rtl/sage_husa_kalman_filter.sv
tb/sv/testbench.sv
